FILE: hw/rtl/hqw_pkg.sv
// Package for the header Q-word encoder: transaction types, register indexes,
// character constants and the byte classification helpers.
// Depends on nothing; every other file of the block imports it.
package hqw_pkg;

    localparam int unsigned CharsetMax   = 8;
    localparam int unsigned CharsetLenW  = 4;
    localparam int unsigned CharsetBitsW = 8 * CharsetMax;
    localparam int unsigned CountW       = 5;    // up to 18 output bytes per input byte
    localparam int unsigned CfgIndexW    = 2;

    localparam logic [CfgIndexW-1:0] REG_CHARSET_BYTES  = 2'd0;
    localparam logic [CfgIndexW-1:0] REG_CHARSET_LENGTH = 2'd1;

    localparam logic [7:0] CH_EQUAL    = 8'h3D;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_UNDER    = 8'h5F;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_Q        = 8'h51;
    localparam logic [7:0] CH_TWO      = 8'h32;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CTRL_LAST   = 8'h1F;
    localparam logic [7:0] CH_DEL      = 8'h7F;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_final;
    } hqw_in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } hqw_out_t;

    // Everything the byte sequencer needs to emit the bytes of one input byte.
    typedef struct packed {
        logic                   prefix;     // opens the encoded word here
        logic [CharsetLenW-1:0] cs_len;     // saturated charset length
        logic                   body3;      // body is a three-byte escape
        logic                   suffix;     // closes the encoded word here
        logic [2:0][7:0]        body;       // body bytes, element 0 first
        logic [CountW-1:0]      count;      // total output bytes
    } hqw_plan_t;

    function automatic logic is_special(input logic [7:0] b);
        return (b == CH_EQUAL) || (b == CH_QUESTION) || (b == CH_UNDER) ||
               (b <= CTRL_LAST) || (b >= CH_DEL);
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10)
            r = CH_ZERO + {4'd0, v};
        else
            r = CH_UPPER_A + {4'd0, v - 4'd10};
        return r;
    endfunction

endpackage

FILE: hw/rtl/hqw_byte_sel.sv
// Output byte selector: picks the byte at a given position of one plan.
// Depends on hqw_pkg for the plan type and the character constants.
module hqw_byte_sel
    import hqw_pkg::*;
(
    input  hqw_plan_t               plan,
    input  logic [CountW-1:0]       idx,
    input  logic [CharsetBitsW-1:0] charset_bytes,
    output logic [7:0]              out_byte,
    output logic                    last
);

    logic [CountW-1:0] body_start;
    logic [CountW-1:0] body_len;
    logic [CountW-1:0] body_off;
    logic [CountW-1:0] cs_end;
    logic [CountW-1:0] cs_off;
    logic [CountW-1:0] tail_off;

    always_comb
    begin
        cs_end     = CountW'(2) + CountW'(plan.cs_len);
        body_start = plan.prefix ? cs_end + CountW'(3) : '0;
        body_len   = plan.body3 ? CountW'(3) : CountW'(1);
        body_off   = idx - body_start;
        cs_off     = idx - CountW'(2);
        tail_off   = idx - cs_end;
        last       = (idx == plan.count - CountW'(1));

        if (plan.prefix && idx < body_start) begin
            // Encoded-word header: "=?", the charset name, then "?Q?".
            if (idx < CountW'(2))
                out_byte = idx[0] ? CH_QUESTION : CH_EQUAL;
            else if (idx < cs_end)
                out_byte = charset_bytes[{cs_off[2:0], 3'b000} +: 8];
            else
                out_byte = (tail_off == CountW'(1)) ? CH_Q : CH_QUESTION;
        end else if (body_off < body_len) begin
            out_byte = plan.body[body_off[1:0]];
        end else begin
            out_byte = (body_off == body_len) ? CH_QUESTION : CH_EQUAL;
        end
    end

endmodule

FILE: hw/rtl/header_q_word_encoder.sv
// Path: an accepted byte is held in the plan register, then moves to the output register;
// throughput: one output byte per cycle while out_stall is low, so an input byte
// yields 1 to 18 output bytes, 1 for a plain byte and 3 in the body of an escape.
// The output byte counter walking the plan register emits them in order.
// Reset: rst_n clears config to zero, returns to the plain phase and empties all stages.
//
// Top level of the header Q-word encoder. Depends on hqw_pkg and hqw_byte_sel.
module header_q_word_encoder
    import hqw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  hqw_in_t                 in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output hqw_out_t                out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIndexW-1:0]    cfg_index,
    input  logic [CharsetBitsW-1:0] cfg_data
);

    // Configuration registers. Writes are accepted every cycle.
    logic [CharsetBitsW-1:0] charset_reg;
    logic [CharsetLenW-1:0]  cs_len_reg;

    // Phase state across the bytes of one header string.
    logic encoding_reg, encoding_next;
    logic blank_reg, blank_next;

    // Plan stage: holds the decoded form of the byte being emitted.
    logic              hold_valid_reg, hold_valid_next;
    hqw_plan_t         plan_reg, plan_next;
    logic [CountW-1:0] idx_reg, idx_next;

    // Output register.
    logic     out_valid_reg, out_valid_next;
    hqw_out_t out_data_reg;

    logic       in_accept;
    logic       advance;
    logic       sel_last;
    logic [7:0] sel_byte;
    logic       b_special;
    logic       b_space;
    logic       plain;
    logic       enc_now;
    logic [CharsetLenW-1:0] len_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            charset_reg <= '0;
            cs_len_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_CHARSET_BYTES:  charset_reg <= cfg_data;
                REG_CHARSET_LENGTH: cs_len_reg  <= cfg_data[CharsetLenW-1:0];
                default: ;
            endcase
        end
    end

    // The output register advances when it is empty or being taken. The plan
    // stage frees up in the same cycle its last byte moves out, so a new input
    // transaction is taken then without a bubble.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = hold_valid_reg && !(advance && sel_last);
    assign in_accept = in_valid && !in_stall;

    // Decode of the incoming byte against the current phase.
    always_comb
    begin
        b_special = is_special(in_data.in_byte);
        b_space   = (in_data.in_byte == CH_SPACE);
        len_sat   = (cs_len_reg > CharsetLenW'(CharsetMax)) ?
                    CharsetLenW'(CharsetMax) : cs_len_reg;

        // A trailing space on a string of only spaces opens an encoded word too.
        plain   = !encoding_reg && !b_special &&
                  !(blank_reg && b_space && in_data.is_final);
        enc_now = encoding_reg || !plain;

        plan_next.prefix = !encoding_reg && !plain;
        plan_next.cs_len = len_sat;
        plan_next.body3  = enc_now && (b_special || b_space);
        plan_next.suffix = enc_now && in_data.is_final;
        if (enc_now && b_special) begin
            plan_next.body[0] = CH_EQUAL;
            plan_next.body[1] = hex_digit(in_data.in_byte[7:4]);
            plan_next.body[2] = hex_digit(in_data.in_byte[3:0]);
        end else if (enc_now && b_space) begin
            plan_next.body[0] = CH_EQUAL;
            plan_next.body[1] = CH_TWO;
            plan_next.body[2] = CH_ZERO;
        end else begin
            plan_next.body[0] = in_data.in_byte;
            plan_next.body[1] = in_data.in_byte;
            plan_next.body[2] = in_data.in_byte;
        end
        plan_next.count = (plan_next.prefix ? CountW'(5) + CountW'(len_sat) : CountW'(0))
                        + (plan_next.body3 ? CountW'(3) : CountW'(1))
                        + (plan_next.suffix ? CountW'(2) : CountW'(0));

        // A final byte always returns the phase state to its reset values.
        if (in_data.is_final) begin
            encoding_next = 1'b0;
            blank_next    = 1'b1;
        end else begin
            encoding_next = enc_now;
            blank_next    = (plain && !b_space) ? 1'b0 : blank_reg;
        end
    end

    hqw_byte_sel u_byte_sel (
        .plan          (plan_reg),
        .idx           (idx_reg),
        .charset_bytes (charset_reg),
        .out_byte      (sel_byte),
        .last          (sel_last)
    );

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;

        if (advance) begin
            out_valid_next = hold_valid_reg;
            if (hold_valid_reg) begin
                if (sel_last) begin
                    hold_valid_next = 1'b0;
                    idx_next        = '0;
                end else begin
                    idx_next = idx_reg + CountW'(1);
                end
            end
        end
        if (in_accept) begin
            hold_valid_next = 1'b1;
            idx_next        = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            encoding_reg   <= 1'b0;
            blank_reg      <= 1'b1;
            hold_valid_reg <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            if (in_accept) begin
                encoding_reg <= encoding_next;
                blank_reg    <= blank_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            plan_reg <= plan_next;
        if (advance && hold_valid_reg) begin
            out_data_reg.out_byte    <= sel_byte;
            out_data_reg.last_of_run <= sel_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The byte counter never runs past the planned byte count.
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> (idx_reg < plan_reg.count))
        else $error("byte counter beyond plan count");

    // An accepted input transaction is always held in the plan stage next cycle.
    a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (hold_valid_reg && idx_reg == '0))
        else $error("accepted transaction not loaded into plan stage");

    // A final byte leaves the block back in the plain phase.
    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_data.is_final) |=> (!encoding_reg && blank_reg))
        else $error("phase state not cleared after final byte");

    // The output register only moves when it is empty or taken.
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled output transaction changed");

endmodule
